// ===== rtl/binary_max_heap_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Heap queue assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define HBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define HBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/hbq_pkg.sv =====
// ----------------------------------------------------------------------------
// hbq_pkg
// Shared types and constants for the binary max-heap queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS_DEF = 16;

    localparam int IN_USER_W  = 2;  // opcode
    localparam int OUT_USER_W = 3;  // status, top_valid

    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_POP_LD,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_DONE
    } t_heap_state;

    typedef struct packed {
        logic       start;
        logic       take;
        logic [1:0] op;
    } t_eng_ctrl;

    typedef struct packed {
        logic       idle;
        logic       done;
        logic [1:0] status;
        logic       top_valid;
    } t_eng_stat;

endpackage

`default_nettype wire

// ===== rtl/binary_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Binary max-heap priority queue with stream ports and a result register.
// ----------------------------------------------------------------------------
// One transaction in gives one result out. A transaction is a query, a push
// or a pop; the result reports status, the top entry and the entry count
// after the operation. One transaction at a time is in work, and the single
// read port of the heap RAM (registered read) sets the pace. A query, a
// rejected operation or a pop that empties the heap goes straight to its
// result. A push sifts the new entry up one level at a time, and a pop
// sifts the last entry down from the root one level at a time. A finished
// result waits in the engine while the output register is still full. A
// new transaction is accepted while the previous result still waits in
// the output register. Equal keys never swap. The heap RAM needs no
// clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue
    import hbq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int IN_DW   = ((KEY_BITS + TAG_BITS + 7) / 8) * 8,
    localparam int OUT_DW  = ((KEY_BITS + TAG_BITS + CNT_W + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DW-1:0]      i_s_axis_tdata,  // entry_key, entry_tag
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,  // opcode
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [OUT_DW-1:0]     o_m_axis_tdata,  // top_key, top_tag, entry_count
    output logic      [OUT_USER_W-1:0] o_m_axis_tuser   // status, top_valid
);

    t_eng_ctrl w_ctrl;
    t_eng_stat w_stat;

    logic [KEY_BITS-1:0] w_top_key;
    logic [TAG_BITS-1:0] w_top_tag;
    logic [CNT_W-1:0]    w_count;

    logic                  r_out_valid, n_out_valid;
    logic [OUT_DW-1:0]     r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    assign o_s_axis_tready = w_stat.idle;

    always_comb begin
        w_ctrl.start = i_s_axis_tvalid && w_stat.idle;
        w_ctrl.op    = i_s_axis_tuser;
        w_ctrl.take  = w_stat.done && (!r_out_valid || i_m_axis_tready);
    end

    hbq_engine #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_key     (i_s_axis_tdata[KEY_BITS-1:0]),
        .i_tag     (i_s_axis_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS]),
        .o_stat    (w_stat),
        .o_top_key (w_top_key),
        .o_top_tag (w_top_tag),
        .o_count   (w_count)
    );

    always_comb begin
        if (w_ctrl.take) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (w_ctrl.take) begin
            r_out_data <= OUT_DW'({w_count, w_top_tag, w_top_key});
            r_out_user <= {w_stat.top_valid, w_stat.status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== rtl/hbq_ram.sv =====
// ----------------------------------------------------------------------------
// hbq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/hbq_engine.sv =====
// ----------------------------------------------------------------------------
// hbq_engine
// Heap sequencer: sift-up / sift-down over the heap RAM with one key compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "binary_max_heap_queue_defines.svh"

module hbq_engine
    import hbq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_eng_ctrl                      i_ctrl,
    input  wire logic [KEY_BITS-1:0]            i_key,
    input  wire logic [TAG_BITS-1:0]            i_tag,
    output t_eng_stat                           o_stat,
    output logic      [KEY_BITS-1:0]            o_top_key,
    output logic      [TAG_BITS-1:0]            o_top_tag,
    output logic      [$clog2(CAPACITY+1)-1:0]  o_count
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int EW     = KEY_BITS + TAG_BITS;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ROOT    = CNT_W'(1);

    t_heap_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [EW-1:0]     r_ent, n_ent;     // entry being sifted
    logic [EW-1:0]     r_best, n_best;   // larger of moving entry and left child
    logic              r_best_l, n_best_l;
    logic              r_has_r, n_has_r;
    logic [1:0]        r_status, n_status;
    logic [EW-1:0]     r_top, n_top;     // copy of slot 1

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [EW-1:0]     w_wdata, w_rdata;

    logic [CNT_W:0]    w_left;
    logic [CNT_W:0]    w_cnt_x;
    logic [CNT_W-1:0]  w_pos_m1;
    logic [CNT_W-1:0]  w_par_m1;
    logic [CNT_W:0]    w_left_m1;
    logic [KEY_BITS-1:0] w_cmp_a, w_cmp_b;
    logic              w_gt;

    hbq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_left    = {r_pos, 1'b0};
    assign w_cnt_x   = {1'b0, r_count};
    assign w_pos_m1  = r_pos - ROOT;
    assign w_par_m1  = (r_pos >> 1) - ROOT;
    assign w_left_m1 = w_left - (CNT_W+1)'(1);

    // shared signed compare: a > b
    always_comb begin
        case (r_state)
            ST_UP_CMP: begin
                w_cmp_a = r_ent[KEY_BITS-1:0];
                w_cmp_b = w_rdata[KEY_BITS-1:0];
            end
            ST_DN_RDR: begin
                w_cmp_a = w_rdata[KEY_BITS-1:0];
                w_cmp_b = r_ent[KEY_BITS-1:0];
            end
            default: begin
                w_cmp_a = w_rdata[KEY_BITS-1:0];
                w_cmp_b = r_best[KEY_BITS-1:0];
            end
        endcase
    end
    assign w_gt = $signed(w_cmp_a) > $signed(w_cmp_b);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    case (i_ctrl.op)
                        OP_PUSH: n_state = (r_count >= CAP_CNT) ? ST_DONE : ST_UP_CHK;
                        OP_POP:  n_state = (r_count > ROOT) ? ST_POP_LD : ST_DONE;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_UP_CHK: n_state = (r_pos == ROOT) ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP: n_state = w_gt ? ST_UP_CHK : ST_DONE;
            ST_POP_LD: n_state = ST_DN_RDL;
            ST_DN_RDL: n_state = (w_left > w_cnt_x) ? ST_DONE : ST_DN_RDR;
            ST_DN_RDR: n_state = ST_DN_CMP;
            ST_DN_CMP: n_state = ((r_has_r && w_gt) || r_best_l) ? ST_DN_RDL : ST_DONE;
            ST_DONE:   n_state = i_ctrl.take ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and RAM control; every write lands at r_pos
    always_comb begin
        n_count  = r_count;
        n_pos    = r_pos;
        n_ent    = r_ent;
        n_best   = r_best;
        n_best_l = r_best_l;
        n_has_r  = r_has_r;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = w_pos_m1[ADDR_W-1:0];
        w_wdata  = r_ent;
        w_raddr  = w_par_m1[ADDR_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_status = STAT_OK;
                    case (i_ctrl.op)
                        OP_PUSH: begin
                            if (r_count >= CAP_CNT) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_count = r_count + ROOT;
                                n_pos   = r_count + ROOT;
                                n_ent   = {i_tag, i_key};
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - ROOT;
                                w_raddr = n_count[ADDR_W-1:0];
                            end
                        end
                        default: n_status = STAT_OK;
                    endcase
                end
            end
            ST_UP_CHK: begin
                if (r_pos == ROOT) begin
                    w_we = 1'b1;
                end
            end
            ST_UP_CMP: begin
                w_we = 1'b1;
                if (w_gt) begin
                    w_wdata = w_rdata;
                    n_pos   = r_pos >> 1;
                end
            end
            ST_POP_LD: begin
                n_ent = w_rdata;
                n_pos = ROOT;
            end
            ST_DN_RDL: begin
                w_raddr = w_left_m1[ADDR_W-1:0];
                if (w_left > w_cnt_x) begin
                    w_we = 1'b1;
                end
            end
            ST_DN_RDR: begin
                w_raddr  = w_left[ADDR_W-1:0];
                n_has_r  = w_left < w_cnt_x;
                n_best_l = w_gt;
                n_best   = w_gt ? w_rdata : r_ent;
            end
            ST_DN_CMP: begin
                w_we = 1'b1;
                if (r_has_r && w_gt) begin
                    w_wdata = w_rdata;
                    n_pos   = w_left[CNT_W-1:0] + ROOT;
                end else if (r_best_l) begin
                    w_wdata = r_best;
                    n_pos   = w_left[CNT_W-1:0];
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        n_top = (w_we && r_pos == ROOT) ? w_wdata : r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_ent    <= n_ent;
        r_best   <= n_best;
        r_best_l <= n_best_l;
        r_has_r  <= n_has_r;
        r_status <= n_status;
        r_top    <= n_top;
    end

    always_comb begin
        o_stat.idle      = (r_state == ST_IDLE);
        o_stat.done      = (r_state == ST_DONE);
        o_stat.status    = r_status;
        o_stat.top_valid = (r_count != '0);
        o_top_key        = o_stat.top_valid ? r_top[KEY_BITS-1:0] : '0;
        o_top_tag        = o_stat.top_valid ? r_top[EW-1:KEY_BITS] : '0;
        o_count          = r_count;
    end

    `HBQ_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT, "count above capacity")
    `HBQ_ASSERT_IMP(a_dn_pos, i_clk, i_rst_n, r_state == ST_DN_RDL, (r_pos >= ROOT) && (r_pos <= r_count), "sift-down position outside heap")
    `HBQ_ASSERT_NXT(a_done_hold, i_clk, i_rst_n, (r_state == ST_DONE) && !i_ctrl.take, r_state == ST_DONE, "result dropped before taken")
    `HBQ_ASSERT_NXT(a_push_cnt, i_clk, i_rst_n, (r_state == ST_IDLE) && i_ctrl.start && (i_ctrl.op == OP_PUSH) && (r_count < CAP_CNT), r_count == $past(r_count) + ROOT, "push did not grow count")

endmodule

`default_nettype wire
